FILE: sv/front_middle_back_queue_top_defines.svh
// Assertion macros for the front/middle/back queue.
// Depends on clk_i and rst_ni being in scope where the macros are used.
`ifndef FRONT_MIDDLE_BACK_QUEUE_TOP_DEFINES_SVH
`define FRONT_MIDDLE_BACK_QUEUE_TOP_DEFINES_SVH

// Check a property at every clock edge outside reset
`define FMBQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("fmbq assertion failed");

// Check that a condition is followed by a consequence in the next cycle
`define FMBQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fmbq assertion failed");

`endif

FILE: sv/fmbq_pkg.sv
// Shared types and constants for the front/middle/back queue.
// No dependencies.
package fmbq_pkg;

  localparam int unsigned Capacity = 16;
  localparam int unsigned IdxW     = $clog2(Capacity);
  localparam int unsigned CntW     = $clog2(Capacity + 1);

  // request kinds
  localparam logic [2:0] KIND_PUSH_FRONT  = 3'd0;
  localparam logic [2:0] KIND_PUSH_MIDDLE = 3'd1;
  localparam logic [2:0] KIND_PUSH_BACK   = 3'd2;
  localparam logic [2:0] KIND_POP_FRONT   = 3'd3;
  localparam logic [2:0] KIND_POP_MIDDLE  = 3'd4;
  localparam logic [2:0] KIND_POP_BACK    = 3'd5;

  // result status codes
  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  localparam logic signed [31:0] NoneValue = -32'sd1;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] popped_value;
    logic [1:0]         status;
  } out_item_t;

  // command from controller to datapath
  typedef struct packed {
    logic            load;    // capture a result this cycle
    logic            ins;     // insert value at pos
    logic            rem;     // remove entry at pos and report it
    logic [IdxW-1:0] pos;
    logic [1:0]      status;
  } dp_cmd_t;

endpackage

FILE: sv/fmbq_ctrl.sv
// Controller for the front/middle/back queue: handshake, fill count, decode.
// Depends on fmbq_pkg.
module fmbq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         kind_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output fmbq_pkg::dp_cmd_t  cmd_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_HOLD = 1'b1;

  logic                      state_q, state_d;
  logic [fmbq_pkg::CntW-1:0] count_q, count_d;
  logic [fmbq_pkg::CntW-1:0] count_m1;
  logic                      accept;
  logic                      is_push, is_pop, full, empty;

  // accept while no result is held, or the held one leaves now
  assign in_ready_o  = (state_q == S_IDLE) || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == S_HOLD);

  assign is_push  = kind_i inside {fmbq_pkg::KIND_PUSH_FRONT, fmbq_pkg::KIND_PUSH_MIDDLE,
                                   fmbq_pkg::KIND_PUSH_BACK};
  assign is_pop   = kind_i inside {fmbq_pkg::KIND_POP_FRONT, fmbq_pkg::KIND_POP_MIDDLE,
                                   fmbq_pkg::KIND_POP_BACK};
  assign full     = (count_q == fmbq_pkg::CntW'(fmbq_pkg::Capacity));
  assign empty    = (count_q == '0);
  assign count_m1 = count_q - fmbq_pkg::CntW'(1);

  // decode the request into a datapath command
  always_comb begin
    cmd_o        = '0;
    cmd_o.load   = accept;
    cmd_o.ins    = accept && is_push && !full;
    cmd_o.rem    = accept && is_pop && !empty;
    cmd_o.status = fmbq_pkg::STATUS_DONE;
    if (is_push && full) begin
      cmd_o.status = fmbq_pkg::STATUS_FULL;
    end else if (is_pop && empty) begin
      cmd_o.status = fmbq_pkg::STATUS_EMPTY;
    end
    case (kind_i)
      fmbq_pkg::KIND_PUSH_FRONT:  cmd_o.pos = '0;
      fmbq_pkg::KIND_PUSH_MIDDLE: cmd_o.pos = count_q[fmbq_pkg::IdxW:1];
      fmbq_pkg::KIND_PUSH_BACK:   cmd_o.pos = count_q[fmbq_pkg::IdxW-1:0];
      fmbq_pkg::KIND_POP_FRONT:   cmd_o.pos = '0;
      fmbq_pkg::KIND_POP_MIDDLE:  cmd_o.pos = count_m1[fmbq_pkg::IdxW:1];
      fmbq_pkg::KIND_POP_BACK:    cmd_o.pos = count_m1[fmbq_pkg::IdxW-1:0];
      default:                    cmd_o.pos = '0;
    endcase
  end

  // advance the state and the fill count
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    if (accept) begin
      state_d = S_HOLD;
    end else if (out_ready_i) begin
      state_d = S_IDLE;
    end
    if (cmd_o.ins) begin
      count_d = count_q + fmbq_pkg::CntW'(1);
    end else if (cmd_o.rem) begin
      count_d = count_m1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

endmodule

FILE: sv/fmbq_dp.sv
// Datapath for the front/middle/back queue: shifting entry cells and result register.
// Depends on fmbq_pkg.
module fmbq_dp (
  input  logic               clk_i,
  input  fmbq_pkg::dp_cmd_t  cmd_i,
  input  logic signed [31:0] value_i,
  output fmbq_pkg::out_item_t out_item_o
);

  logic signed [31:0] entries_q [fmbq_pkg::Capacity];
  logic signed [31:0] entries_d [fmbq_pkg::Capacity];
  fmbq_pkg::out_item_t out_q;

  // each cell takes its own value, the new value, or a neighbour's value
  always_comb begin
    for (int i = 0; i < int'(fmbq_pkg::Capacity); i++) begin
      entries_d[i] = entries_q[i];
      if (cmd_i.ins) begin
        if (fmbq_pkg::IdxW'(i) == cmd_i.pos) begin
          entries_d[i] = value_i;
        end else if ((i > 0) && (fmbq_pkg::IdxW'(i) > cmd_i.pos)) begin
          entries_d[i] = entries_q[(i > 0) ? i - 1 : 0];
        end
      end else if (cmd_i.rem) begin
        if ((i < int'(fmbq_pkg::Capacity) - 1) && (fmbq_pkg::IdxW'(i) >= cmd_i.pos)) begin
          entries_d[i] = entries_q[(i < int'(fmbq_pkg::Capacity) - 1) ? i + 1 : i];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < int'(fmbq_pkg::Capacity); i++) begin
      entries_q[i] <= entries_d[i];
    end
  end

  // capture the result of an accepted item
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_q.popped_value <= cmd_i.rem ? entries_q[cmd_i.pos] : fmbq_pkg::NoneValue;
      out_q.status       <= cmd_i.status;
    end
  end

  assign out_item_o = out_q;

endmodule

FILE: sv/front_middle_back_queue_top.sv
// Front/middle/back queue of 16 signed 32-bit values, one request per item.
// The result is registered and appears in the cycle after the item is accepted.
// Throughput: one item per cycle while results are taken; all shifting cells move in the same cycle.
// A held result that is not taken stalls input until it leaves.
// Reset (rst_ni, async, active low) empties the queue and drops any held result;
// entry contents are not cleared.
`include "front_middle_back_queue_top_defines.svh"

module front_middle_back_queue_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  fmbq_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output fmbq_pkg::out_item_t out_item_o
);

  fmbq_pkg::dp_cmd_t cmd;
  logic              res_failed;

  fmbq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (in_item_i.kind),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  fmbq_dp u_dp (
    .clk_i      (clk_i),
    .cmd_i      (cmd),
    .value_i    (in_item_i.value),
    .out_item_o (out_item_o)
  );

  // flag a held result that reports a failed request
  assign res_failed = out_valid_o && (out_item_o.status != fmbq_pkg::STATUS_DONE);

  // an accepted item yields a result in the next cycle
  `FMBQ_ASSERT_NEXT(a_result_follows, in_valid_i && in_ready_o, out_valid_o)
  // a held result is never overwritten by a new item
  `FMBQ_ASSERT(a_no_overwrite, (out_valid_o && !out_ready_i) |-> !in_ready_o)
  // failed requests report the none value
  `FMBQ_ASSERT(a_fail_none, res_failed |-> (out_item_o.popped_value == fmbq_pkg::NoneValue))

endmodule
